[hw/rtl/ptts_pkg.sv]
// Shared types and constants for the periodic task tick scheduler.
`timescale 1ns / 1ps

package ptts_pkg;

  // Fixed widths of the command word fields and of the fire mask.
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned DELAY_W  = 16;
  localparam int unsigned MASK_W   = 8;

  // Default configuration of the slot table.
  localparam int unsigned DEF_NUM_TASKS   = 8;
  localparam int unsigned DEF_COUNT_WIDTH = 16;

  typedef enum logic [FUNC_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_CREATE  = 3'd1,
    CMD_SUSPEND = 3'd2,
    CMD_RESUME  = 3'd3,
    CMD_DELETE  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DONE
  } state_e;

  // Command strobes from the controller to the datapath.
  typedef struct packed {
    logic create;
    logic suspend;
    logic resume;
    logic delete_slot;
    logic tick_start;
    logic rd_en;
    logic upd_en;
  } dp_cmd_t;

endpackage

[hw/rtl/periodic_task_tick_scheduler.sv]
// Top level of the periodic task tick scheduler: controller plus datapath.
`timescale 1ns / 1ps
//
// Usage: one command word is taken at a rising edge where start is high and
// busy is low. func_i selects tick, create, suspend, resume or delete;
// slot_i names the slot, and period_i and first_delay_i are used by create.
// Create, suspend, resume and delete complete at the accepting edge, so busy
// stays low and a new word may follow in the very next cycle. They give no
// result, nor do unused command codes or a slot beyond the table.
// A tick scans the slot table one slot per cycle: each slot is read from the
// period and countdown memories in one cycle and written back in the next,
// overlapped with the read of the following slot. After the last slot is
// written back, the DONE state raises fire_valid_o with fire_mask_o; busy is
// already low there, so the next word may be taken in that same cycle. A new
// tick is thus taken only once the previous tick's scan is through; the memory
// port and the one slot visit per cycle set this. Reset clears every ready
// flag and marks every stored period and countdown as zero through per-slot
// valid bits; no clearing pass is needed. The receiver of results cannot
// stall: each result word is present for exactly one cycle and must be taken then.

module periodic_task_tick_scheduler #(
  parameter int unsigned NUM_TASKS   = ptts_pkg::DEF_NUM_TASKS,
  parameter int unsigned COUNT_WIDTH = ptts_pkg::DEF_COUNT_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [ptts_pkg::FUNC_W-1:0]   func_i,
  input  logic [ptts_pkg::SLOT_W-1:0]   slot_i,
  input  logic [ptts_pkg::PERIOD_W-1:0] period_i,
  input  logic [ptts_pkg::DELAY_W-1:0]  first_delay_i,
  output logic                          fire_valid_o,
  output logic [ptts_pkg::MASK_W-1:0]   fire_mask_o
);

  localparam int unsigned IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  ptts_pkg::dp_cmd_t dp_cmd;
  logic [IDX_W-1:0]  cmd_idx;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  upd_idx;

  // The controller decodes command words and sequences the slot scan.
  ptts_ctrl #(
    .NUM_TASKS (NUM_TASKS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .slot_i       (slot_i),
    .cmd_o        (dp_cmd),
    .cmd_idx_o    (cmd_idx),
    .rd_idx_o     (rd_idx),
    .upd_idx_o    (upd_idx),
    .fire_valid_o (fire_valid_o)
  );

  // The datapath holds the slot table and builds the fire mask.
  ptts_datapath #(
    .NUM_TASKS   (NUM_TASKS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .cmd_idx_i     (cmd_idx),
    .rd_idx_i      (rd_idx),
    .upd_idx_i     (upd_idx),
    .period_i      (period_i),
    .first_delay_i (first_delay_i),
    .fire_mask_o   (fire_mask_o)
  );

  // Every accepted tick yields its result once its scan is through.
  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (func_i == ptts_pkg::CMD_TICK)) |-> ##(NUM_TASKS + 2) fire_valid_o)
    else $error("tick result not delivered on time");

  // The block only becomes busy because a tick was taken.
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && (func_i == ptts_pkg::CMD_TICK)))
    else $error("busy raised without a tick");

  // Results never come in adjacent cycles and only while not busy.
  a_result_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_valid_o |-> !busy ##1 !fire_valid_o)
    else $error("result strobe malformed");

endmodule

[hw/rtl/ptts_ctrl.sv]
// Controller state machine: command decode and the slot scan sequencer.
`timescale 1ns / 1ps

module ptts_ctrl #(
  parameter int unsigned NUM_TASKS = ptts_pkg::DEF_NUM_TASKS,
  localparam int unsigned IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [ptts_pkg::FUNC_W-1:0] func_i,
  input  logic [ptts_pkg::SLOT_W-1:0] slot_i,
  output ptts_pkg::dp_cmd_t           cmd_o,
  output logic [IDX_W-1:0]            cmd_idx_o,
  output logic [IDX_W-1:0]            rd_idx_o,
  output logic [IDX_W-1:0]            upd_idx_o,
  output logic                        fire_valid_o
);

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(NUM_TASKS - 1);

  ptts_pkg::state_e state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             slot_ok;
  logic             can_take;

  assign slot_ok   = 32'(slot_i) < 32'(NUM_TASKS);
  assign cmd_idx_o = IDX_W'(slot_i);
  assign rd_idx_o  = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptts_pkg::ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    cmd_o        = '0;
    upd_idx_o    = idx_q;
    fire_valid_o = 1'b0;
    can_take     = 1'b0;

    case (state_q)
      ptts_pkg::ST_IDLE, ptts_pkg::ST_DONE: begin
        can_take     = 1'b1;
        fire_valid_o = (state_q == ptts_pkg::ST_DONE);
        state_d      = ptts_pkg::ST_IDLE;
      end
      ptts_pkg::ST_SCAN: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.upd_en = (idx_q != '0);
        upd_idx_o    = idx_q - IDX_W'(1);
        if (idx_q == LastIdx) begin
          state_d = ptts_pkg::ST_LAST;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ptts_pkg::ST_LAST: begin
        cmd_o.upd_en = 1'b1;
        state_d      = ptts_pkg::ST_DONE;
      end
      default: begin
        state_d = ptts_pkg::ST_IDLE;
      end
    endcase

    if (can_take && start) begin
      case (func_i)
        ptts_pkg::CMD_TICK: begin
          cmd_o.tick_start = 1'b1;
          idx_d            = '0;
          state_d          = ptts_pkg::ST_SCAN;
        end
        ptts_pkg::CMD_CREATE:  cmd_o.create      = slot_ok;
        ptts_pkg::CMD_SUSPEND: cmd_o.suspend     = slot_ok;
        ptts_pkg::CMD_RESUME:  cmd_o.resume      = slot_ok;
        ptts_pkg::CMD_DELETE:  cmd_o.delete_slot = slot_ok;
        default: ;
      endcase
    end
  end

  assign busy = !can_take;

endmodule

[hw/rtl/ptts_datapath.sv]
// Datapath: slot table storage, countdown update and the fire mask.
`timescale 1ns / 1ps

module ptts_datapath #(
  parameter int unsigned NUM_TASKS   = ptts_pkg::DEF_NUM_TASKS,
  parameter int unsigned COUNT_WIDTH = ptts_pkg::DEF_COUNT_WIDTH,
  localparam int unsigned IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ptts_pkg::dp_cmd_t             cmd_i,
  input  logic [IDX_W-1:0]              cmd_idx_i,
  input  logic [IDX_W-1:0]              rd_idx_i,
  input  logic [IDX_W-1:0]              upd_idx_i,
  input  logic [ptts_pkg::PERIOD_W-1:0] period_i,
  input  logic [ptts_pkg::DELAY_W-1:0]  first_delay_i,
  output logic [ptts_pkg::MASK_W-1:0]   fire_mask_o
);

  logic [COUNT_WIDTH-1:0] period_mem [NUM_TASKS];
  logic [COUNT_WIDTH-1:0] count_mem  [NUM_TASKS];

  logic [NUM_TASKS-1:0] ready_q, ready_d;
  logic [NUM_TASKS-1:0] per_vld_q, per_vld_d;
  logic [NUM_TASKS-1:0] cnt_vld_q, cnt_vld_d;
  logic [ptts_pkg::MASK_W-1:0] mask_q, mask_d;

  logic [COUNT_WIDTH-1:0] per_rd_q, cnt_rd_q;
  logic [COUNT_WIDTH-1:0] cur_per, cur_cnt, new_cnt;
  logic                   upd_live, upd_fire;

  logic                   cnt_we, per_we;
  logic [IDX_W-1:0]       cnt_wa;
  logic [COUNT_WIDTH-1:0] cnt_wd;

  // Entries never written read as zero through the valid bits.
  assign cur_per  = per_vld_q[upd_idx_i] ? per_rd_q : '0;
  assign cur_cnt  = cnt_vld_q[upd_idx_i] ? cnt_rd_q : '0;
  assign upd_live = cmd_i.upd_en && ready_q[upd_idx_i];
  assign upd_fire = upd_live && (cur_cnt == '0);
  assign new_cnt  = (cur_cnt == '0) ? (cur_per - COUNT_WIDTH'(1))
                                    : (cur_cnt - COUNT_WIDTH'(1));

  always_comb begin
    per_we = cmd_i.create;
    cnt_we = cmd_i.create || upd_live;
    cnt_wa = cmd_i.create ? cmd_idx_i : upd_idx_i;
    cnt_wd = cmd_i.create ? COUNT_WIDTH'(first_delay_i) : new_cnt;
  end

  always_comb begin
    ready_d   = ready_q;
    per_vld_d = per_vld_q;
    cnt_vld_d = cnt_vld_q;
    mask_d    = mask_q;
    if (cmd_i.create) begin
      ready_d[cmd_idx_i]   = 1'b1;
      per_vld_d[cmd_idx_i] = 1'b1;
      cnt_vld_d[cmd_idx_i] = 1'b1;
    end
    if (cmd_i.resume) begin
      ready_d[cmd_idx_i] = 1'b1;
    end
    if (cmd_i.suspend) begin
      ready_d[cmd_idx_i] = 1'b0;
    end
    if (cmd_i.delete_slot) begin
      ready_d[cmd_idx_i]   = 1'b0;
      per_vld_d[cmd_idx_i] = 1'b0;
      cnt_vld_d[cmd_idx_i] = 1'b0;
    end
    if (upd_live) begin
      cnt_vld_d[upd_idx_i] = 1'b1;
    end
    if (cmd_i.tick_start) begin
      mask_d = '0;
    end
    for (int b = 0; b < ptts_pkg::MASK_W; b++) begin
      if (upd_fire && (32'(upd_idx_i) == 32'(b))) begin
        mask_d[b] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q   <= '0;
      per_vld_q <= '0;
      cnt_vld_q <= '0;
      mask_q    <= '0;
    end else begin
      ready_q   <= ready_d;
      per_vld_q <= per_vld_d;
      cnt_vld_q <= cnt_vld_d;
      mask_q    <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (per_we) begin
      period_mem[cmd_idx_i] <= COUNT_WIDTH'(period_i);
    end
    if (cnt_we) begin
      count_mem[cnt_wa] <= cnt_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      per_rd_q <= period_mem[rd_idx_i];
      cnt_rd_q <= count_mem[rd_idx_i];
    end
  end

  assign fire_mask_o = mask_q;

endmodule

[verif/ptts_fire_checker.sv]
// Checker that predicts and compares the fire masks of the periodic task tick scheduler.
`timescale 1ns / 1ps

module ptts_fire_checker #(
  parameter int unsigned NUM_TASKS   = ptts_pkg::DEF_NUM_TASKS,
  parameter int unsigned COUNT_WIDTH = ptts_pkg::DEF_COUNT_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic [ptts_pkg::FUNC_W-1:0]   func_i,
  input  logic [ptts_pkg::SLOT_W-1:0]   slot_i,
  input  logic [ptts_pkg::PERIOD_W-1:0] period_i,
  input  logic [ptts_pkg::DELAY_W-1:0]  first_delay_i,
  input  logic                          fire_valid_i,
  input  logic [ptts_pkg::MASK_W-1:0]   fire_mask_i,
  output int unsigned                   mismatches_o,
  output int unsigned                   pending_o,
  output int unsigned                   masks_checked_o,
  output int unsigned                   masks_nonzero_o
);

  import ptts_pkg::*;

  logic                   armed_q  [NUM_TASKS];
  logic [COUNT_WIDTH-1:0] reload_q [NUM_TASKS];
  logic [COUNT_WIDTH-1:0] remain_q [NUM_TASKS];

  logic [MASK_W-1:0] due_masks [$];
  logic [MASK_W-1:0] want_mask;
  int unsigned       mismatches = 0;
  int unsigned       checked    = 0;
  int unsigned       nonzero    = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // One tick: every armed slot either fires and reloads, or counts down.
  function automatic logic [MASK_W-1:0] advance_tick();
    logic [MASK_W-1:0] fired;
    fired = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (armed_q[i]) begin
        if (remain_q[i] == '0) begin
          if (i < MASK_W) fired[i] = 1'b1;
          remain_q[i] = reload_q[i] - 1'b1;
        end else begin
          remain_q[i] = remain_q[i] - 1'b1;
        end
      end
    end
    return fired;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        armed_q[i]  = 1'b0;
        reload_q[i] = '0;
        remain_q[i] = '0;
      end
      due_masks.delete();
    end else begin
      // The result of an earlier tick is checked before a word taken at the
      // same edge is predicted.
      if (fire_valid_i) begin
        if (due_masks.size() == 0) begin
          report_mismatch($sformatf("fire mask %02h with no tick outstanding", fire_mask_i));
        end else begin
          want_mask = due_masks.pop_front();
          checked++;
          if (want_mask != '0) nonzero++;
          if (fire_mask_i !== want_mask) begin
            report_mismatch($sformatf("fire_mask expected %02h, got %02h",
                                      want_mask, fire_mask_i));
          end
        end
      end
      if (start_i && !busy_i) begin
        if (func_i == CMD_TICK) begin
          due_masks.push_back(advance_tick());
        end else if (slot_i < NUM_TASKS) begin
          case (func_i)
            CMD_CREATE: begin
              reload_q[slot_i] = COUNT_WIDTH'(period_i);
              remain_q[slot_i] = COUNT_WIDTH'(first_delay_i);
              armed_q[slot_i]  = 1'b1;
            end
            CMD_SUSPEND: armed_q[slot_i] = 1'b0;
            CMD_RESUME:  armed_q[slot_i] = 1'b1;
            CMD_DELETE: begin
              reload_q[slot_i] = '0;
              remain_q[slot_i] = '0;
              armed_q[slot_i]  = 1'b0;
            end
            default: ;
          endcase
        end
      end
    end
    mismatches_o    <= mismatches;
    pending_o       <= due_masks.size();
    masks_checked_o <= checked;
    masks_nonzero_o <= nonzero;
  end

endmodule

[verif/periodic_task_tick_scheduler_tb.sv]
// Testbench top for the periodic task tick scheduler: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_tb;

  import ptts_pkg::*;

  localparam int unsigned NUM_TASKS      = DEF_NUM_TASKS;
  localparam int unsigned COUNT_WIDTH    = DEF_COUNT_WIDTH;
  localparam int unsigned CLK_HALF       = 10;
  localparam int unsigned RESET_CYCLES   = 4;
  localparam int unsigned RANDOM_WORDS   = 1000;
  localparam int unsigned CALM_TAIL      = 150;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  // Command codes above delete are unused by the block and must be ignored.
  localparam int unsigned LAST_FUNC      = (1 << FUNC_W) - 1;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                start         = 1'b0;
  logic                busy;
  logic [FUNC_W-1:0]   func_i        = '0;
  logic [SLOT_W-1:0]   slot_i        = '0;
  logic [PERIOD_W-1:0] period_i      = '0;
  logic [DELAY_W-1:0]  first_delay_i = '0;
  logic                fire_valid_o;
  logic [MASK_W-1:0]   fire_mask_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned masks_checked;
  int unsigned masks_nonzero;

  int unsigned func_count [LAST_FUNC+1];
  int unsigned quiet_cycles = 0;
  int unsigned idle_odds    = 0;
  bit          calm         = 1'b0;

  // A 20 ns clock; the first rising edge falls at 10 ns.
  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  periodic_task_tick_scheduler #(
    .NUM_TASKS   (NUM_TASKS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .slot_i        (slot_i),
    .period_i      (period_i),
    .first_delay_i (first_delay_i),
    .fire_valid_o  (fire_valid_o),
    .fire_mask_o   (fire_mask_o)
  );

  // The checker sits beside the block, watching both channels on its own.
  ptts_fire_checker #(
    .NUM_TASKS   (NUM_TASKS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_fire_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .func_i          (func_i),
    .slot_i          (slot_i),
    .period_i        (period_i),
    .first_delay_i   (first_delay_i),
    .fire_valid_i    (fire_valid_o),
    .fire_mask_i     (fire_mask_o),
    .mismatches_o    (mismatches),
    .pending_o       (pending),
    .masks_checked_o (masks_checked),
    .masks_nonzero_o (masks_nonzero)
  );

  // The watchdog counts cycles in which neither a command word nor a fire mask
  // is taken. A tick's scan and an idle burst each fall far short of the limit,
  // so a correct run never comes close to it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || fire_valid_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired after %0d quiet cycles at %0t ns", quiet_cycles, $time);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Presents one command word and returns at the edge that takes it. Start is
  // left high so that a following word can go out back to back; only a pause
  // or the end of the random part lowers it.
  task automatic issue_word(input logic [FUNC_W-1:0] f, input logic [SLOT_W-1:0] s,
                            input logic [PERIOD_W-1:0] p, input logic [DELAY_W-1:0] d);
    start         <= 1'b1;
    func_i        <= f;
    slot_i        <= s;
    period_i      <= p;
    first_delay_i <= d;
    do @(posedge clk_i); while (busy);
    func_count[f]++;
  endtask

  // Random idle bursts between words. As a burst can begin while a tick is
  // still being scanned, the gaps land on every phase of the scan.
  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 99) < idle_odds) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // Periods and delays are mostly short so that slots fire often; now and then
  // the extremes, and otherwise any 16-bit value so that every bit toggles.
  function automatic logic [PERIOD_W-1:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return PERIOD_W'($urandom_range(0, 7));
    if (roll == 6) return '0;
    if (roll == 7) return '1;
    return PERIOD_W'($urandom);
  endfunction

  // Mostly ticks and creates, so that the table stays populated and fires,
  // with suspends, resumes, deletes and the odd unused code mixed in.
  task automatic random_word(output bit counted);
    int unsigned       roll;
    logic [FUNC_W-1:0] f;
    roll = $urandom_range(0, 99);
    if (roll < 45)      f = CMD_TICK;
    else if (roll < 65) f = CMD_CREATE;
    else if (roll < 75) f = CMD_SUSPEND;
    else if (roll < 85) f = CMD_RESUME;
    else if (roll < 93) f = CMD_DELETE;
    else                f = FUNC_W'($urandom_range(CMD_DELETE + 1, LAST_FUNC));
    counted = (f <= CMD_DELETE);
    issue_word(f, SLOT_W'($urandom), pick_count(), pick_count());
  endtask

  initial begin
    int unsigned done_words;
    bit          counted;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening. A tick on an empty table must give an empty mask.
    issue_word(CMD_TICK, '0, '0, '0);
    // Period and delay at both extremes, a period of one and a plain pair.
    issue_word(CMD_CREATE, 3'd0, '0, '0);
    issue_word(CMD_CREATE, 3'd7, '1, '1);
    issue_word(CMD_CREATE, 3'd3, 16'd1, '0);
    issue_word(CMD_CREATE, 3'd5, 16'd2, 16'd1);
    // Slot 0 fires at once and, having a period of zero, reloads the maximum.
    issue_word(CMD_TICK, '0, '0, '0);
    issue_word(CMD_TICK, '0, '0, '0);
    issue_word(CMD_TICK, '0, '0, '0);
    // A suspended slot is skipped and keeps its count until resumed.
    issue_word(CMD_SUSPEND, 3'd3, '0, '0);
    issue_word(CMD_TICK, '0, '0, '0);
    issue_word(CMD_RESUME, 3'd3, '0, '0);
    issue_word(CMD_TICK, '0, '0, '0);
    // A deleted slot that is resumed fires on the next tick and reloads the
    // maximum count, its period having been cleared.
    issue_word(CMD_DELETE, 3'd0, 16'h1234, 16'h5678);
    issue_word(CMD_RESUME, 3'd0, '0, '0);
    issue_word(CMD_TICK, '0, '0, '0);
    issue_word(CMD_TICK, '0, '0, '0);
    // Unused command codes, with busy fields, must change nothing.
    for (int c = CMD_DELETE + 1; c <= LAST_FUNC; c++) begin
      issue_word(FUNC_W'(c), SLOT_W'($urandom), PERIOD_W'($urandom), DELAY_W'($urandom));
    end
    issue_word(CMD_DELETE, 3'd7, '0, '0);
    issue_word(CMD_CREATE, 3'd1, '0, 16'd1);
    issue_word(CMD_TICK, '0, '0, '0);
    issue_word(CMD_TICK, '0, '0, '0);

    // Random part. The idling rate changes every few dozen words, zero among
    // the choices, and the tail runs with no idling at all.
    done_words = 0;
    while (done_words < RANDOM_WORDS) begin
      if (done_words % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_odds = 0;
          1:       idle_odds = 25;
          default: idle_odds = 50;
        endcase
      end
      calm = (done_words >= RANDOM_WORDS - CALM_TAIL);
      random_word(counted);
      if (counted) done_words++;
      maybe_pause();
    end
    start <= 1'b0;

    // Drain: wait for the masks still owed, then a scan's worth of cycles so
    // that any stray result would still be seen.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (NUM_TASKS + 4) @(posedge clk_i);

    $display("Sent %0d ticks, %0d creates, %0d suspends, %0d resumes, %0d deletes",
             func_count[CMD_TICK], func_count[CMD_CREATE], func_count[CMD_SUSPEND],
             func_count[CMD_RESUME], func_count[CMD_DELETE]);
    $display("and %0d unused codes; %0d fire masks checked, %0d of them with slots firing.",
             func_count[5] + func_count[6] + func_count[7], masks_checked, masks_nonzero);
    if (mismatches == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/ptts_pkg.sv
hw/rtl/ptts_ctrl.sv
hw/rtl/ptts_datapath.sv
hw/rtl/periodic_task_tick_scheduler.sv
verif/ptts_fire_checker.sv
verif/periodic_task_tick_scheduler_tb.sv
